/* src/mac_pkg.sv */
`default_nettype none

package mac_pkg;

    localparam int PRICE_W = 16;
    localparam int MARGIN_W = 16;
    localparam int SIG_W = 2;

    localparam int SHORT_WINDOW_DEF = 10;
    localparam int LONG_WINDOW_DEF = 30;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd3277;

    localparam logic [SIG_W-1:0] SIG_NONE = 2'd0;
    localparam logic [SIG_W-1:0] SIG_BUY = 2'd1;
    localparam logic [SIG_W-1:0] SIG_SELL = 2'd2;

    // Load enables of the two register stages of a constant divider
    typedef struct packed {
        logic mul;
        logic fix;
    } div_en_t;

endpackage

`default_nettype wire

/* src/mac_in_if.sv */
`default_nettype none

interface mac_in_if;
    logic                         valid;
    logic                         ready;
    logic                         has_price;
    logic [mac_pkg::PRICE_W-1:0]  price;

    modport source (output valid, output has_price, output price, input ready);
    modport sink (input valid, input has_price, input price, output ready);
endinterface

`default_nettype wire

/* src/mac_out_if.sv */
`default_nettype none

interface mac_out_if;
    logic                         valid;
    logic                         ready;
    logic [mac_pkg::SIG_W-1:0]    trade_signal;
    logic [mac_pkg::PRICE_W-1:0]  short_mean;
    logic [mac_pkg::PRICE_W-1:0]  long_mean;

    modport source (output valid, output trade_signal, output short_mean,
                    output long_mean, input ready);
    modport sink (input valid, input trade_signal, input short_mean,
                  input long_mean, output ready);
endinterface

`default_nettype wire

/* src/mac_cfg_if.sv */
`default_nettype none

interface mac_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mac_pkg::MARGIN_W-1:0]  margin;

    modport source (output valid, output margin, input ready);
    modport sink (input valid, input margin, output ready);
endinterface

`default_nettype wire

/* src/mac_cell.sv */
`default_nettype none

module mac_cell
(
    input  wire logic                         clk,
    input  wire logic                         shift,
    input  wire logic [mac_pkg::PRICE_W-1:0]  din,
    output logic      [mac_pkg::PRICE_W-1:0]  dout
);

    logic [mac_pkg::PRICE_W-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= din;
        end
    end

    assign dout = value_reg;

endmodule

`default_nettype wire

/* src/mac_history.sv */
`default_nettype none

module mac_history
#(
    parameter int DEPTH = 30,
    parameter int SHORT_TAP = 10,
    parameter int LONG_TAP = 30
)
(
    input  wire logic                         clk,
    input  wire logic                         shift,
    input  wire logic [mac_pkg::PRICE_W-1:0]  din,
    output logic      [mac_pkg::PRICE_W-1:0]  tap_short,
    output logic      [mac_pkg::PRICE_W-1:0]  tap_long
);

    logic [mac_pkg::PRICE_W-1:0] chain [DEPTH];

    // Cell 0 holds the newest price; cell k holds the price k beats older than it
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            mac_cell u_cell (.clk(clk), .shift(shift), .din(din), .dout(chain[k]));
        end
        else
        begin : g_body
            mac_cell u_cell (.clk(clk), .shift(shift), .din(chain[k-1]), .dout(chain[k]));
        end
    end

    assign tap_short = chain[SHORT_TAP-1];
    assign tap_long  = chain[LONG_TAP-1];

endmodule

`default_nettype wire

/* src/mac_cdiv.sv */
`default_nettype none

module mac_cdiv
#(
    parameter int WIDTH = 20,
    parameter int DIVISOR = 10
)
(
    input  wire logic                    clk,
    input  wire mac_pkg::div_en_t        en,
    input  wire logic [WIDTH-1:0]        x,
    output logic      [WIDTH-1:0]        q
);

    localparam int RW = WIDTH + 1;
    localparam int PW = WIDTH + RW;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << WIDTH) / DIVISOR);
    localparam logic [WIDTH-1:0] DIV_W = WIDTH'(DIVISOR);

    logic [PW-1:0]    prod_reg;
    logic [WIDTH-1:0] x_reg;
    logic [WIDTH-1:0] q_reg;
    logic [WIDTH-1:0] q0;
    logic [WIDTH-1:0] back;
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] q_next;

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_reg <= PW'(x) * PW'(RECIP);
            x_reg    <= x;
        end
        if (en.fix)
        begin
            q_reg <= q_next;
        end
    end

    // Estimate is low by at most one; fix with one compare and subtract
    always_comb
    begin
        q0     = prod_reg[2*WIDTH-1:WIDTH];
        back   = q0 * DIV_W;
        rem    = x_reg - back;
        q_next = (rem >= DIV_W) ? q0 + WIDTH'(1) : q0;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

/* src/moving_average_crossover_detector.sv */
// Pipeline: a result beat is registered through stages b, c, d and e after its input beat is accepted.
// Throughput: one input beat per cycle unless result.ready stalls; the running-sum
// update in the input stage sets that figure, one add and one subtract per beat.
// Reset: sums, fill count, trend mode and latched signal clear, margin returns to 3277.
// The price history cells are not cleared; no cell is read before it is written.
`default_nettype none

module moving_average_crossover_detector
#(
    parameter int SHORT_WINDOW = mac_pkg::SHORT_WINDOW_DEF,
    parameter int LONG_WINDOW = mac_pkg::LONG_WINDOW_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mac_in_if.sink     tick,
    mac_out_if.source  result,
    mac_cfg_if.sink    cfg
);

    localparam int PW = mac_pkg::PRICE_W;
    localparam int HIST = (SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
    localparam int FW = $clog2(HIST + 1);
    localparam int SSW = PW + $clog2(SHORT_WINDOW + 1);
    localparam int LSW = PW + $clog2(LONG_WINDOW + 1);
    localparam int SCW = PW + $clog2(SHORT_WINDOW + 1) + $clog2(LONG_WINDOW + 1);
    localparam int MW = SCW + mac_pkg::MARGIN_W;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_HIGH,
        MODE_LOW
    } mode_t;

    // Configuration
    logic [mac_pkg::MARGIN_W-1:0] margin_reg;

    // Running state
    logic [FW-1:0]  fill_reg;
    logic [FW-1:0]  fill_next;
    logic [SSW-1:0] short_sum_reg;
    logic [SSW-1:0] short_sum_next;
    logic [LSW-1:0] long_sum_reg;
    logic [LSW-1:0] long_sum_next;
    logic [PW-1:0]  tap_short;
    logic [PW-1:0]  tap_long;
    logic           accept;
    logic           shift;

    // Pipeline stages
    logic           b_v_reg, b_has_reg, b_full_reg;
    logic [SSW-1:0] b_s_reg;
    logic [LSW-1:0] b_l_reg;

    logic           c_v_reg, c_has_reg, c_full_reg;
    logic [SSW-1:0] c_s_reg;
    logic [LSW-1:0] c_l_reg;
    logic [SCW-1:0] c_ss_reg;
    logic [SCW-1:0] c_ls_reg;

    logic           d_v_reg, d_has_reg, d_full_reg;
    logic [MW-1:0]  d_sm_reg;
    logic [SCW-1:0] d_diff_reg;
    logic           d_s_gt_reg, d_l_gt_reg;

    logic           e_v_reg;
    mode_t          mode_reg;
    logic [mac_pkg::SIG_W-1:0] trade_reg;

    logic ready_b, ready_c, ready_d, ready_e;
    logic sell, buy;
    logic [MW-1:0] diff_up;

    logic [SSW-1:0] s_div_x;
    logic [LSW-1:0] l_div_x;
    logic [SSW-1:0] s_avg;
    logic [LSW-1:0] l_avg;
    mac_pkg::div_en_t div_en;

    assign ready_e = !e_v_reg || result.ready;
    assign ready_d = !d_v_reg || ready_e;
    assign ready_c = !c_v_reg || ready_d;
    assign ready_b = !b_v_reg || ready_c;

    assign tick.ready = ready_b;
    assign accept = tick.valid && ready_b;
    assign shift = accept && tick.has_price;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= mac_pkg::MARGIN_RESET;
        end
        else if (cfg.valid)
        begin
            margin_reg <= cfg.margin;
        end
    end

    mac_history #(
        .DEPTH(HIST),
        .SHORT_TAP(SHORT_WINDOW),
        .LONG_TAP(LONG_WINDOW)
    ) u_history (
        .clk(clk),
        .shift(shift),
        .din(tick.price),
        .tap_short(tap_short),
        .tap_long(tap_long)
    );

    // Drop the price leaving each window once that window is full, add the new one
    always_comb
    begin
        short_sum_next = short_sum_reg;
        long_sum_next  = long_sum_reg;
        fill_next      = fill_reg;
        if (tick.has_price)
        begin
            short_sum_next = short_sum_reg + SSW'(tick.price)
                - ((fill_reg >= FW'(SHORT_WINDOW)) ? SSW'(tap_short) : SSW'(0));
            long_sum_next = long_sum_reg + LSW'(tick.price)
                - ((fill_reg >= FW'(LONG_WINDOW)) ? LSW'(tap_long) : LSW'(0));
            if (fill_reg != FW'(HIST))
            begin
                fill_next = fill_reg + FW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
        end
        else if (accept)
        begin
            fill_reg      <= fill_next;
            short_sum_reg <= short_sum_next;
            long_sum_reg  <= long_sum_next;
        end
    end

    // Valid bits of the middle stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else
        begin
            if (ready_b)
            begin
                b_v_reg <= tick.valid;
            end
            if (ready_c)
            begin
                c_v_reg <= b_v_reg;
            end
            if (ready_d)
            begin
                d_v_reg <= c_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_b)
        begin
            b_has_reg  <= tick.has_price;
            b_full_reg <= (fill_next == FW'(HIST));
            b_s_reg    <= short_sum_next;
            b_l_reg    <= long_sum_next;
        end
        if (ready_c)
        begin
            c_has_reg  <= b_has_reg;
            c_full_reg <= b_full_reg;
            c_s_reg    <= b_s_reg;
            c_l_reg    <= b_l_reg;
            c_ss_reg   <= SCW'(b_s_reg) * SCW'(LONG_WINDOW);
            c_ls_reg   <= SCW'(b_l_reg) * SCW'(SHORT_WINDOW);
        end
        if (ready_d)
        begin
            d_has_reg  <= c_has_reg;
            d_full_reg <= c_full_reg;
            d_sm_reg   <= MW'(c_ss_reg) * MW'(margin_reg);
            d_s_gt_reg <= c_ss_reg > c_ls_reg;
            d_l_gt_reg <= c_ls_reg > c_ss_reg;
            d_diff_reg <= (c_ss_reg > c_ls_reg) ? c_ss_reg - c_ls_reg : c_ls_reg - c_ss_reg;
        end
    end

    // Averages read zero until the history is full
    assign s_div_x = c_full_reg ? c_s_reg : '0;
    assign l_div_x = c_full_reg ? c_l_reg : '0;
    assign div_en.mul = ready_d;
    assign div_en.fix = ready_e;

    mac_cdiv #(.WIDTH(SSW), .DIVISOR(SHORT_WINDOW)) u_short_div (
        .clk(clk),
        .en(div_en),
        .x(s_div_x),
        .q(s_avg)
    );

    mac_cdiv #(.WIDTH(LSW), .DIVISOR(LONG_WINDOW)) u_long_div (
        .clk(clk),
        .en(div_en),
        .x(l_div_x),
        .q(l_avg)
    );

    // Scaled gap between the windows against the margin share of the short sum
    assign diff_up = {d_diff_reg, {mac_pkg::MARGIN_W{1'b0}}};
    assign sell = d_l_gt_reg && (diff_up > d_sm_reg);
    assign buy  = d_s_gt_reg && (diff_up > d_sm_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg   <= 1'b0;
            mode_reg  <= MODE_NONE;
            trade_reg <= mac_pkg::SIG_NONE;
        end
        else if (ready_e)
        begin
            e_v_reg <= d_v_reg;
            if (d_v_reg && !d_full_reg)
            begin
                trade_reg <= mac_pkg::SIG_NONE;
            end
            else if (d_v_reg && d_has_reg)
            begin
                case (mode_reg)
                    MODE_HIGH:
                    begin
                        if (sell)
                        begin
                            mode_reg  <= MODE_LOW;
                            trade_reg <= mac_pkg::SIG_SELL;
                        end
                    end
                    MODE_LOW:
                    begin
                        if (buy)
                        begin
                            mode_reg  <= MODE_HIGH;
                            trade_reg <= mac_pkg::SIG_BUY;
                        end
                    end
                    default:
                    begin
                        trade_reg <= mac_pkg::SIG_NONE;
                        mode_reg  <= d_s_gt_reg ? MODE_HIGH : MODE_LOW;
                    end
                endcase
            end
        end
    end

    assign result.valid        = e_v_reg;
    assign result.trade_signal = trade_reg;
    assign result.short_mean   = s_avg[PW-1:0];
    assign result.long_mean    = l_avg[PW-1:0];

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(HIST))
        else $error("fill count beyond history depth");

    a_none_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_NONE) |-> (trade_reg == mac_pkg::SIG_NONE))
        else $error("signal latched while trend undetermined");

    a_trade_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (trade_reg != $past(trade_reg)) |-> $past(ready_e && d_v_reg))
        else $error("signal changed without a decision beat");

endmodule

`default_nettype wire
